[src/lpds_pkg.sv]
`default_nettype none
package lpds_pkg;

  localparam logic KIND_SPLAT = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [2:0] REG_IMG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_MAX_DIST   = 3'd2;
  localparam logic [2:0] REG_POINT_SIZE = 3'd3;
  localparam logic [2:0] REG_FULL_MODE  = 3'd4;

  localparam logic [7:0] SHADE_MAX = 8'd255;

  typedef struct packed {
    logic [10:0] frame_w;
    logic [9:0]  frame_h;
    logic [17:0] max_dist_mm;
    logic [3:0]  point_size;
    logic        full_distance_mode;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic signed [11:0] col;
    logic signed [11:0] row;
    logic [7:0]         shade_ctr;
    logic [7:0]         shade_win;
    logic [3:0]         half;
  } entry_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_SQRT,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_RD,
    B_WR
  } back_state_t;

endpackage
`default_nettype wire

[src/lpds_if.sv]
`default_nettype none
interface lpds_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [11:0] col;
  logic signed [11:0] row;
  logic signed [18:0] x_mm;
  logic signed [18:0] y_mm;
  logic signed [18:0] z_mm;
  modport source (output valid, kind, col, row, x_mm, y_mm, z_mm, input ready);
  modport sink (input valid, kind, col, row, x_mm, y_mm, z_mm, output ready);
endinterface

interface lpds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  modport source (output valid, pixel_value, input ready);
  modport sink (input valid, pixel_value, output ready);
endinterface
`default_nettype wire

[src/lpds_front.sv]
`default_nettype none
module lpds_front import lpds_pkg::*; #(
  parameter int MAX_POINT_SIZE = 15
) (
  input  logic   clk,
  input  logic   rst,
  lpds_in_if.sink req,
  input  cfg_t   cfg,
  input  logic   hold,
  output entry_t push_data,
  output logic   push,
  input  logic   full
);

  front_state_t st, st_next;

  logic [4:0]         cnt;
  logic               pass;
  logic               kind;
  logic signed [11:0] col;
  logic signed [11:0] row;
  logic signed [18:0] x;
  logic signed [18:0] y;
  logic signed [18:0] z;
  logic [3:0]         half;
  logic               use_win;
  logic [36:0]        prod;
  logic [37:0]        acc;
  logic [37:0]        sq_n;
  logic [38:0]        sq_res;
  logic [37:0]        sq_bit;
  logic [28:0]        rem;
  logic [24:0]        dsh;
  logic [7:0]         quo;
  logic               sat;
  logic [7:0]         shade_c;
  logic [7:0]         shade_w;

  logic [4:0]         ps_eff;
  logic signed [18:0] mul_op;
  logic signed [37:0] mul_full;
  logic [38:0]        sq_try;
  logic [18:0]        dist_mm;
  logic signed [20:0] diff;
  logic [19:0]        v_win;
  logic [19:0]        v_sel;
  logic [17:0]        m;
  logic [25:0]        m255;
  logic [28:0]        n_div;
  logic [7:0]         shade_new;
  logic               accept;

  assign accept = req.valid && req.ready;

  always_comb begin
    ps_eff = (cfg.point_size == 4'd0) ? 5'd1 : {1'b0, cfg.point_size};
    if (ps_eff > 5'(MAX_POINT_SIZE)) begin
      ps_eff = 5'(MAX_POINT_SIZE);
    end
  end

  always_comb begin
    case (cnt[1:0])
      2'd0:    mul_op = x;
      2'd1:    mul_op = y;
      default: mul_op = z;
    endcase
    mul_full = mul_op * mul_op;
    sq_try = sq_res + {1'b0, sq_bit};
    dist_mm = sq_res[18:0];
    diff = $signed({2'b00, dist_mm}) - 21'(z);
    if (cfg.full_distance_mode) begin
      v_win = {1'b0, dist_mm};
    end else if (diff < 0) begin
      v_win = 20'd0;
    end else begin
      v_win = diff[19:0];
    end
    v_sel = pass ? v_win : {1'b0, dist_mm};
    m = (cfg.max_dist_mm == 18'd0) ? 18'd1 : cfg.max_dist_mm;
    m255 = {m, 8'd0} - 26'(m);
    n_div = 29'({v_sel, 8'd0}) - 29'(v_sel) + 29'(m) - 29'd1;
    shade_new = sat ? 8'd0 : SHADE_MAX - quo;
  end

  always_comb begin
    st_next = st;
    case (st)
      F_IDLE: begin
        if (accept) begin
          st_next = (req.kind == KIND_READ) ? F_PUSH : F_MUL;
        end
      end
      F_MUL: begin
        if (cnt == 5'd3) begin
          st_next = F_SQRT;
        end
      end
      F_SQRT: begin
        if (cnt == 5'd18) begin
          st_next = F_DIV;
        end
      end
      F_DIV: begin
        if (cnt == 5'd9 && pass) begin
          st_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full) begin
          st_next = F_IDLE;
        end
      end
      default: st_next = F_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (st == F_IDLE) && !hold;
    push = (st == F_PUSH) && !full;
    push_data.kind = kind;
    push_data.col = col;
    push_data.row = row;
    push_data.half = half;
    push_data.shade_win = shade_w;
    push_data.shade_ctr = (use_win && shade_w > shade_c) ? shade_w : shade_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
      cnt <= '0;
      pass <= 1'b0;
    end else begin
      st <= st_next;
      if (st != st_next) begin
        cnt <= '0;
        pass <= 1'b0;
      end else if (st == F_DIV && cnt == 5'd9) begin
        cnt <= '0;
        pass <= 1'b1;
      end else begin
        cnt <= cnt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= req.kind;
      col <= req.col;
      row <= req.row;
      x <= req.x_mm;
      y <= req.y_mm;
      z <= req.z_mm;
      half <= (req.kind == KIND_READ) ? 4'd0 : 4'((ps_eff - 5'd1) >> 1);
      use_win <= (req.kind == KIND_SPLAT) && (ps_eff > 5'd1);
      shade_c <= '0;
      shade_w <= '0;
    end
    case (st)
      F_MUL: begin
        prod <= mul_full[36:0];
        case (cnt[1:0])
          2'd0:    acc <= '0;
          2'd1:    acc <= 38'(prod);
          2'd2:    acc <= acc + 38'(prod);
          default: begin
            sq_n <= acc + 38'(prod);
            sq_res <= '0;
            sq_bit <= 38'd1 << 36;
          end
        endcase
      end
      F_SQRT: begin
        if ({1'b0, sq_n} >= sq_try) begin
          sq_n <= 38'({1'b0, sq_n} - sq_try);
          sq_res <= (sq_res >> 1) + {1'b0, sq_bit};
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      F_DIV: begin
        if (cnt == 5'd0) begin
          rem <= n_div;
          dsh <= {m, 7'd0};
          quo <= '0;
          sat <= (n_div >= 29'(m255));
        end else if (cnt <= 5'd8) begin
          if (rem >= 29'(dsh)) begin
            rem <= rem - 29'(dsh);
            quo <= {quo[6:0], 1'b1};
          end else begin
            quo <= {quo[6:0], 1'b0};
          end
          dsh <= dsh >> 1;
        end else if (pass) begin
          shade_w <= shade_new;
        end else begin
          shade_c <= shade_new;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[src/lpds_queue.sv]
`default_nettype none
module lpds_queue import lpds_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output entry_t head,
  output logic   empty
);

  entry_t     slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= push_data;
    end
  end

endmodule
`default_nettype wire

[src/lpds_back.sv]
`default_nettype none
module lpds_back import lpds_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  entry_t head,
  input  logic   empty,
  output logic   pop,
  output logic   clearing,
  lpds_out_if.source rsp
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(DEPTH);
  localparam logic signed [13:0] MW_S = 14'(MAX_WIDTH);
  localparam logic signed [13:0] MH_S = 14'(MAX_HEIGHT);

  logic [7:0] mem [DEPTH];

  back_state_t st, st_next;

  entry_t            cur;
  logic signed [4:0] j;
  logic signed [4:0] k;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     addr_q;
  logic              inside_q;
  logic [7:0]        rd_q;
  logic              out_valid;
  logic [7:0]        out_data;

  logic signed [4:0]  h;
  logic signed [13:0] pc;
  logic signed [13:0] pr;
  logic               inside_w;
  logic [AW-1:0]      addr_w;
  logic               last;
  logic [7:0]         shade_pix;
  logic               out_free;
  logic               load_out;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_wa;
  logic [7:0]         mem_wd;

  always_comb begin
    h = $signed({1'b0, cur.half});
    pc = 14'(cur.col) + 14'(k);
    pr = 14'(cur.row) + 14'(j);
    inside_w = (pc >= 0) && (pr >= 0)
            && (pc < $signed({3'b000, cfg.frame_w}))
            && (pr < $signed({4'b0000, cfg.frame_h}))
            && (pc < MW_S) && (pr < MH_S);
    addr_w = AW'(AW'(unsigned'(pr)) * AW'(MAX_WIDTH)) + AW'(unsigned'(pc));
    last = (k == h) && (j == h);
    shade_pix = (j == 5'sd0 && k == 5'sd0) ? cur.shade_ctr : cur.shade_win;
    out_free = !out_valid || rsp.ready;
  end

  always_comb begin
    st_next = st;
    case (st)
      B_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          st_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty) begin
          st_next = B_RD;
        end
      end
      B_RD: st_next = B_WR;
      B_WR: begin
        if (cur.kind == KIND_READ) begin
          if (out_free) begin
            st_next = B_IDLE;
          end
        end else if (last) begin
          st_next = B_IDLE;
        end else begin
          st_next = B_RD;
        end
      end
      default: st_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop = (st == B_IDLE) && !empty;
    clearing = (st == B_CLEAR);
    load_out = (st == B_WR) && (cur.kind == KIND_READ) && out_free;
    mem_re = (st == B_RD) && inside_w;
    mem_we = 1'b0;
    mem_wa = addr_q;
    mem_wd = 8'd0;
    case (st)
      B_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
      end
      B_WR: begin
        if (cur.kind == KIND_READ) begin
          mem_we = inside_q;
        end else begin
          mem_we = inside_q && (shade_pix > rd_q);
          mem_wd = shade_pix;
        end
      end
      default: ;
    endcase
    rsp.valid = out_valid;
    rsp.pixel_value = out_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[addr_w];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= B_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (st == B_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      j <= -$signed({1'b0, head.half});
      k <= -$signed({1'b0, head.half});
    end
    if (st == B_RD) begin
      addr_q <= addr_w;
      inside_q <= inside_w;
    end
    if (st == B_WR && cur.kind == KIND_SPLAT && !last) begin
      if (k == h) begin
        k <= -h;
        j <= j + 5'sd1;
      end else begin
        k <= k + 5'sd1;
      end
    end
    if (load_out) begin
      out_data <= inside_q ? rd_q : 8'd0;
    end
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    (st == B_CLEAR) |-> !pop)
    else $error("queue popped during clear");

  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    (st == B_WR && cur.kind == KIND_READ && mem_we) |-> (mem_wd == 8'd0))
    else $error("read did not clear pixel");

  a_max_blend: assert property (@(posedge clk) disable iff (rst)
    (st == B_WR && cur.kind == KIND_SPLAT && mem_we) |-> (mem_wd > rd_q))
    else $error("splat lowered a pixel");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || rsp.ready))
    else $error("result overwrote pending beat");

endmodule
`default_nettype wire

[src/lidar_point_depth_splatter_unit.sv]
// Splat item: the front does 3 squarings, 19 square-root steps and two shade
// divisions, then the back visits the (2h+1)^2 window pixels, one frame-store
// port doing read then write per pixel. Read item: skips the front math; the back
// reads the pixel, returns it and clears it. Front and back overlap via a 2-deep queue.
// Reset: registers take their defaults, then the back clears the frame store one
// byte a cycle; no item is accepted until that ends.
`default_nettype none
module lidar_point_depth_splatter_unit import lpds_pkg::*; #(
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_HEIGHT     = 512,
  parameter int MAX_POINT_SIZE = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  lpds_in_if.sink     req,
  lpds_out_if.source  rsp
);

  cfg_t       cfg;
  logic [2:0] idx;
  logic       wr_en;
  entry_t     push_data;
  entry_t     head;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  logic       clearing;

  assign pready = 1'b1;
  assign idx = paddr[4:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_w <= 11'd640;
      cfg.frame_h <= 10'd512;
      cfg.max_dist_mm <= 18'd50000;
      cfg.point_size <= 4'd1;
      cfg.full_distance_mode <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_IMG_WIDTH:  cfg.frame_w <= pwdata[10:0];
        REG_IMG_HEIGHT: cfg.frame_h <= pwdata[9:0];
        REG_MAX_DIST:   cfg.max_dist_mm <= pwdata[17:0];
        REG_POINT_SIZE: cfg.point_size <= pwdata[3:0];
        REG_FULL_MODE:  cfg.full_distance_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IMG_WIDTH:  prdata = 32'(cfg.frame_w);
      REG_IMG_HEIGHT: prdata = 32'(cfg.frame_h);
      REG_MAX_DIST:   prdata = 32'(cfg.max_dist_mm);
      REG_POINT_SIZE: prdata = 32'(cfg.point_size);
      REG_FULL_MODE:  prdata = 32'(cfg.full_distance_mode);
      default:        prdata = 32'd0;
    endcase
  end

  lpds_front #(
    .MAX_POINT_SIZE(MAX_POINT_SIZE)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .req(req),
    .cfg(cfg),
    .hold(clearing),
    .push_data(push_data),
    .push(push),
    .full(full)
  );

  lpds_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .full(full),
    .pop(pop),
    .head(head),
    .empty(empty)
  );

  lpds_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .head(head),
    .empty(empty),
    .pop(pop),
    .clearing(clearing),
    .rsp(rsp)
  );

endmodule
`default_nettype wire
